/* rtl/sfv_pkg.sv */
package sfv_pkg;

  localparam int LEN_BITS = 32;
  localparam int NUM_CMDS = 16;
  localparam int NUM_KEYS = 20;

  // parse phases
  localparam logic [2:0] PH_CMD   = 3'd0;
  localparam logic [2:0] PH_LINE  = 3'd1;
  localparam logic [2:0] PH_KEY   = 3'd2;
  localparam logic [2:0] PH_VAL   = 3'd3;
  localparam logic [2:0] PH_BLEN  = 3'd4;
  localparam logic [2:0] PH_BNUL  = 3'd5;
  localparam logic [2:0] PH_TRAIL = 3'd6;

  // byte classes
  localparam logic [2:0] KIND_CMD   = 3'd0;
  localparam logic [2:0] KIND_KEY   = 3'd1;
  localparam logic [2:0] KIND_VAL   = 3'd2;
  localparam logic [2:0] KIND_DELIM = 3'd3;
  localparam logic [2:0] KIND_BODY  = 3'd4;
  localparam logic [2:0] KIND_OTHER = 3'd5;

  // status codes
  localparam logic [3:0] ST_OK          = 4'd0;
  localparam logic [3:0] ST_BAD_CMD     = 4'd1;
  localparam logic [3:0] ST_HDR_MISSING = 4'd2;
  localparam logic [3:0] ST_NO_NL       = 4'd3;
  localparam logic [3:0] ST_HDR_NO_NL   = 4'd4;
  localparam logic [3:0] ST_BAD_KEY     = 4'd5;
  localparam logic [3:0] ST_EMPTY_VAL   = 4'd6;
  localparam logic [3:0] ST_NO_COLON    = 4'd7;
  localparam logic [3:0] ST_BAD_LEN     = 4'd8;
  localparam logic [3:0] ST_NO_BLANK    = 4'd9;
  localparam logic [3:0] ST_NO_NULL     = 4'd10;
  localparam logic [3:0] ST_LENGTH      = 4'd11;
  localparam logic [3:0] ST_JUNK        = 4'd12;
  localparam logic [3:0] ST_UNKNOWN_CMD = 4'd13;

  localparam logic [4:0] HDR_CLEN    = 5'd2;
  localparam logic [3:0] CMD_UNKNOWN = 4'd15;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  // one result item
  typedef struct packed {
    logic [3:0] command_code;
    logic [3:0] status_code;
    logic       frame_done;
    logic [4:0] header_code;
    logic [2:0] byte_kind;
    logic [7:0] echo_byte;
  } result_t;

  // command names, right aligned, last char in the low byte
  function automatic logic [127:0] cmd_name(input logic [3:0] i);
    logic [127:0] s;
    unique case (i)
      4'd0:  s = "ABORT";
      4'd1:  s = "ACK";
      4'd2:  s = "BEGIN";
      4'd3:  s = "COMMIT";
      4'd4:  s = "CONNECT";
      4'd5:  s = "CONNECTED";
      4'd6:  s = "DISCONNECT";
      4'd7:  s = "ERROR";
      4'd8:  s = "MESSAGE";
      4'd9:  s = "NACK";
      4'd10: s = "RECEIPT";
      4'd11: s = "SEND";
      4'd12: s = "STOMP";
      4'd13: s = "SUBSCRIBE";
      4'd14: s = "UNSUBSCRIBE";
      default: s = "UNKNOWN COMMAND";
    endcase
    return s;
  endfunction

  function automatic logic [4:0] cmd_len(input logic [3:0] i);
    logic [4:0] n;
    unique case (i)
      4'd0:  n = 5'd5;
      4'd1:  n = 5'd3;
      4'd2:  n = 5'd5;
      4'd3:  n = 5'd6;
      4'd4:  n = 5'd7;
      4'd5:  n = 5'd9;
      4'd6:  n = 5'd10;
      4'd7:  n = 5'd5;
      4'd8:  n = 5'd7;
      4'd9:  n = 5'd4;
      4'd10: n = 5'd7;
      4'd11: n = 5'd4;
      4'd12: n = 5'd5;
      4'd13: n = 5'd9;
      4'd14: n = 5'd11;
      default: n = 5'd15;
    endcase
    return n;
  endfunction

  function automatic logic [127:0] key_name(input logic [4:0] i);
    logic [127:0] s;
    unique case (i)
      5'd0:  s = "accept-version";
      5'd1:  s = "ack";
      5'd2:  s = "content-length";
      5'd3:  s = "content-type";
      5'd4:  s = "destination";
      5'd5:  s = "heart-beat";
      5'd6:  s = "host";
      5'd7:  s = "id";
      5'd8:  s = "login";
      5'd9:  s = "message";
      5'd10: s = "message-id";
      5'd11: s = "passcode";
      5'd12: s = "receipt";
      5'd13: s = "receipt-id";
      5'd14: s = "session";
      5'd15: s = "subscription";
      5'd16: s = "transaction";
      5'd17: s = "server";
      5'd18: s = "version";
      default: s = "unknown header";
    endcase
    return s;
  endfunction

  function automatic logic [4:0] key_len(input logic [4:0] i);
    logic [4:0] n;
    unique case (i)
      5'd0:  n = 5'd14;
      5'd1:  n = 5'd3;
      5'd2:  n = 5'd14;
      5'd3:  n = 5'd12;
      5'd4:  n = 5'd11;
      5'd5:  n = 5'd10;
      5'd6:  n = 5'd4;
      5'd7:  n = 5'd2;
      5'd8:  n = 5'd5;
      5'd9:  n = 5'd7;
      5'd10: n = 5'd10;
      5'd11: n = 5'd8;
      5'd12: n = 5'd7;
      5'd13: n = 5'd10;
      5'd14: n = 5'd7;
      5'd15: n = 5'd12;
      5'd16: n = 5'd11;
      5'd17: n = 5'd6;
      5'd18: n = 5'd7;
      default: n = 5'd14;
    endcase
    return n;
  endfunction

  // true when the name holds character c at position pos
  function automatic logic name_hit(input logic [127:0] s, input logic [4:0] len,
                                    input logic [3:0] pos, input logic [7:0] c);
    logic [3:0] back;
    logic [7:0] ch;
    back = 4'(len - 5'd1 - {1'b0, pos});
    ch = s[{back, 3'b000} +: 8];
    return ({1'b0, pos} < len) && (ch == c);
  endfunction

  // headers each command requires
  function automatic logic [NUM_KEYS-1:0] need_mask(input logic [3:0] i);
    logic [NUM_KEYS-1:0] m;
    m = '0;
    unique case (i)
      4'd0, 4'd2, 4'd3: m[16] = 1'b1;
      4'd1, 4'd9, 4'd14: m[7] = 1'b1;
      4'd4, 4'd12: begin
        m[0] = 1'b1;
        m[6] = 1'b1;
      end
      4'd5: m[18] = 1'b1;
      4'd8: begin
        m[4] = 1'b1;
        m[10] = 1'b1;
        m[15] = 1'b1;
      end
      4'd10: m[13] = 1'b1;
      4'd11: m[4] = 1'b1;
      4'd13: begin
        m[4] = 1'b1;
        m[7] = 1'b1;
      end
      default: m = '0;
    endcase
    return m;
  endfunction

endpackage

/* rtl/stomp_frame_validator.sv */
// Frame validator for the STOMP text protocol, one byte per request.
// Slave channel: s_axis_tdata carries a raw frame byte, s_axis_tlast marks
// the final byte of the frame. Master channel: one result per input byte,
// echoing the byte with its class, header code on value bytes, and on the
// byte with m_axis_tlast set the frame status and matched command.
// A result is registered as its byte is taken, or in the skid entry while the
// receiver stalls. Throughput: one byte per cycle unless stalled; parser state
// is one register set updated per byte by one name-mask and length pass.
// Reset (rst, synchronous) returns the parser to the start of a frame and
// empties the output stage. The parser also returns to the start of a frame
// after every last byte on its own.
// When the receiver stalls, the result stays on m_axis_* and one more byte
// is still taken into a skid entry; s_axis_tready then drops until the
// receiver takes a result.
module stomp_frame_validator (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  logic        s_axis_tlast,   // frame_last
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // [7:0] echo_byte, [10:8] byte_kind,
                                      // [15:11] header_code, [19:16] status_code,
                                      // [23:20] command_code
  output logic        m_axis_tlast    // frame_done
);

  logic             push;
  sfv_pkg::result_t step_result;
  sfv_pkg::result_t out_result;

  assign push = s_axis_tvalid && s_axis_tready;

  sfv_parser u_parser (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .data_byte  (s_axis_tdata),
    .frame_last (s_axis_tlast),
    .result     (step_result)
  );

  sfv_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (step_result),
    .ready     (s_axis_tready),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_data  (out_result)
  );

  assign m_axis_tdata = {out_result.command_code, out_result.status_code,
                         out_result.header_code, out_result.byte_kind,
                         out_result.echo_byte};
  assign m_axis_tlast = out_result.frame_done;

endmodule

/* rtl/sfv_parser.sv */
module sfv_parser (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  logic [7:0]          data_byte,
  input  logic                frame_last,
  output sfv_pkg::result_t    result
);

  logic [2:0]                   phase, phase_next;
  logic [sfv_pkg::NUM_CMDS-1:0] cmd_cand, cmd_cand_next;
  logic [3:0]                   pos, pos_next;
  logic [sfv_pkg::NUM_KEYS-1:0] key_cand, key_cand_next;
  logic                         lf_colon, lf_colon_next;
  logic                         lf_value, lf_value_next;
  logic                         lf_keyok, lf_keyok_next;
  logic [4:0]                   cur_key, cur_key_next;
  logic [sfv_pkg::NUM_KEYS-1:0] seen, seen_next;
  logic [sfv_pkg::LEN_BITS-1:0] len_val, len_val_next;
  logic                         len_digit, len_digit_next;
  logic                         len_stop, len_stop_next;
  logic [sfv_pkg::LEN_BITS-1:0] body_cnt, body_cnt_next;
  logic [3:0]                   err, err_next;
  logic [3:0]                   cmd_found, cmd_found_next;

  // candidate narrowing and exact matches
  logic [sfv_pkg::NUM_CMDS-1:0] cmd_narrow;
  logic [sfv_pkg::NUM_KEYS-1:0] key_narrow;
  logic                         cmd_exact, key_exact;
  logic [3:0]                   cmd_idx;
  logic [4:0]                   key_idx;

  always_comb begin
    cmd_narrow = cmd_cand;
    cmd_exact  = 1'b0;
    cmd_idx    = '0;
    for (int i = sfv_pkg::NUM_CMDS - 1; i >= 0; i--) begin
      if (!sfv_pkg::name_hit(sfv_pkg::cmd_name(4'(i)), sfv_pkg::cmd_len(4'(i)),
                             pos, data_byte))
        cmd_narrow[i] = 1'b0;
      if (cmd_cand[i] && sfv_pkg::cmd_len(4'(i)) == {1'b0, pos}) begin
        cmd_exact = 1'b1;
        cmd_idx   = 4'(i);
      end
    end
  end

  always_comb begin
    key_narrow = key_cand;
    key_exact  = 1'b0;
    key_idx    = '0;
    for (int i = sfv_pkg::NUM_KEYS - 1; i >= 0; i--) begin
      if (!sfv_pkg::name_hit(sfv_pkg::key_name(5'(i)), sfv_pkg::key_len(5'(i)),
                             pos, data_byte))
        key_narrow[i] = 1'b0;
      if (key_cand[i] && sfv_pkg::key_len(5'(i)) == {1'b0, pos}) begin
        key_exact = 1'b1;
        key_idx   = 5'(i);
      end
    end
  end

  // saturating decimal accumulate: x*10 + d
  logic [sfv_pkg::LEN_BITS+3:0] len_acc;
  logic                         is_digit;
  assign is_digit = (data_byte >= sfv_pkg::CH_ZERO) && (data_byte <= sfv_pkg::CH_NINE);
  assign len_acc  = ({4'd0, len_val} << 3) + ({4'd0, len_val} << 1)
                  + {(sfv_pkg::LEN_BITS + 4 - 4)'(0), 4'(data_byte - sfv_pkg::CH_ZERO)};

  logic [2:0] ph;
  logic [2:0] kind;
  logic [4:0] hcode;
  logic [3:0] status;
  logic [sfv_pkg::NUM_KEYS-1:0] need;

  // per-byte parse step
  always_comb begin
    phase_next     = phase;
    cmd_cand_next  = cmd_cand;
    pos_next       = pos;
    key_cand_next  = key_cand;
    lf_colon_next  = lf_colon;
    lf_value_next  = lf_value;
    lf_keyok_next  = lf_keyok;
    cur_key_next   = cur_key;
    seen_next      = seen;
    len_val_next   = len_val;
    len_digit_next = len_digit;
    len_stop_next  = len_stop;
    body_cnt_next  = body_cnt;
    err_next       = err;
    cmd_found_next = cmd_found;
    kind           = sfv_pkg::KIND_OTHER;
    hcode          = '0;
    ph             = phase;

    if (err == sfv_pkg::ST_OK) begin
      if (phase == sfv_pkg::PH_LINE && data_byte != sfv_pkg::CH_LF)
        ph = sfv_pkg::PH_KEY;
      phase_next = ph;
      unique case (ph)
        sfv_pkg::PH_CMD: begin
          if (data_byte == sfv_pkg::CH_LF) begin
            kind = sfv_pkg::KIND_DELIM;
            if (cmd_exact) begin
              cmd_found_next = cmd_idx;
              phase_next     = sfv_pkg::PH_LINE;
              pos_next       = '0;
              key_cand_next  = '1;
              lf_colon_next  = 1'b0;
              lf_value_next  = 1'b0;
              lf_keyok_next  = 1'b0;
              cur_key_next   = '0;
            end else begin
              err_next = sfv_pkg::ST_BAD_CMD;
            end
          end else begin
            kind          = sfv_pkg::KIND_CMD;
            cmd_cand_next = cmd_narrow;
            if (pos != 4'd15) pos_next = pos + 4'd1;
          end
        end
        sfv_pkg::PH_LINE: begin
          // blank line ends the headers
          kind = sfv_pkg::KIND_DELIM;
          if (seen[sfv_pkg::HDR_CLEN]) begin
            if (len_digit) begin
              phase_next    = sfv_pkg::PH_BLEN;
              body_cnt_next = '0;
            end else begin
              err_next = sfv_pkg::ST_BAD_LEN;
            end
          end else begin
            phase_next = sfv_pkg::PH_BNUL;
          end
        end
        sfv_pkg::PH_KEY: begin
          if (data_byte == sfv_pkg::CH_LF) begin
            kind     = sfv_pkg::KIND_DELIM;
            err_next = sfv_pkg::ST_NO_COLON;
          end else if (data_byte == sfv_pkg::CH_COLON) begin
            kind          = sfv_pkg::KIND_DELIM;
            lf_colon_next = 1'b1;
            if (key_exact) begin
              cur_key_next  = key_idx;
              lf_keyok_next = 1'b1;
            end
            phase_next = sfv_pkg::PH_VAL;
          end else begin
            kind          = sfv_pkg::KIND_KEY;
            key_cand_next = key_narrow;
            if (pos != 4'd15) pos_next = pos + 4'd1;
          end
        end
        sfv_pkg::PH_VAL: begin
          if (data_byte == sfv_pkg::CH_LF) begin
            kind = sfv_pkg::KIND_DELIM;
            if (!lf_value) begin
              err_next = sfv_pkg::ST_EMPTY_VAL;
            end else if (!lf_keyok) begin
              err_next = sfv_pkg::ST_BAD_KEY;
            end else begin
              seen_next[cur_key] = 1'b1;
              phase_next    = sfv_pkg::PH_LINE;
              pos_next      = '0;
              key_cand_next = '1;
              lf_colon_next = 1'b0;
              lf_value_next = 1'b0;
              lf_keyok_next = 1'b0;
              cur_key_next  = '0;
            end
          end else begin
            kind          = sfv_pkg::KIND_VAL;
            lf_value_next = 1'b1;
            if (lf_keyok) begin
              hcode = cur_key;
              // first content-length only, leading digits only
              if (cur_key == sfv_pkg::HDR_CLEN && !seen[sfv_pkg::HDR_CLEN] && !len_stop) begin
                if (is_digit) begin
                  if (len_acc[sfv_pkg::LEN_BITS+3:sfv_pkg::LEN_BITS] != 4'd0)
                    len_val_next = '1;
                  else
                    len_val_next = len_acc[sfv_pkg::LEN_BITS-1:0];
                  len_digit_next = 1'b1;
                end else begin
                  len_stop_next = 1'b1;
                end
              end
            end
          end
        end
        sfv_pkg::PH_BLEN: begin
          if (body_cnt < len_val) begin
            kind          = sfv_pkg::KIND_BODY;
            body_cnt_next = body_cnt + 1'b1;
          end else if (data_byte == sfv_pkg::CH_NUL) begin
            kind       = sfv_pkg::KIND_DELIM;
            phase_next = sfv_pkg::PH_TRAIL;
          end else begin
            err_next = sfv_pkg::ST_NO_NULL;
          end
        end
        sfv_pkg::PH_BNUL: begin
          if (data_byte == sfv_pkg::CH_NUL) begin
            kind       = sfv_pkg::KIND_DELIM;
            phase_next = sfv_pkg::PH_TRAIL;
          end else begin
            kind = sfv_pkg::KIND_BODY;
          end
        end
        default: begin
          if (data_byte != sfv_pkg::CH_LF) err_next = sfv_pkg::ST_JUNK;
        end
      endcase
    end
  end

  // end-of-frame verdict
  assign need = sfv_pkg::need_mask(cmd_found_next);

  always_comb begin
    status = err_next;
    if (err_next == sfv_pkg::ST_OK) begin
      unique case (phase_next)
        sfv_pkg::PH_LINE: status = sfv_pkg::ST_NO_BLANK;
        sfv_pkg::PH_KEY, sfv_pkg::PH_VAL: status = sfv_pkg::ST_HDR_NO_NL;
        sfv_pkg::PH_BLEN:
          status = (body_cnt_next == len_val_next) ? sfv_pkg::ST_NO_NULL
                                                   : sfv_pkg::ST_LENGTH;
        sfv_pkg::PH_BNUL: status = sfv_pkg::ST_NO_NULL;
        sfv_pkg::PH_TRAIL: begin
          if (cmd_found_next == sfv_pkg::CMD_UNKNOWN)
            status = sfv_pkg::ST_UNKNOWN_CMD;
          else if ((seen_next & need) != need)
            status = sfv_pkg::ST_HDR_MISSING;
          else
            status = sfv_pkg::ST_OK;
        end
        default: status = sfv_pkg::ST_NO_NL;
      endcase
    end
  end

  always_comb begin
    result.echo_byte    = data_byte;
    result.byte_kind    = kind;
    result.header_code  = hcode;
    result.frame_done   = frame_last;
    result.status_code  = frame_last ? status : sfv_pkg::ST_OK;
    result.command_code = frame_last ? cmd_found_next : 4'd0;
  end

  // parser state; everything returns to reset after the last byte
  always_ff @(posedge clk) begin
    if (rst || (push && frame_last)) begin
      phase     <= sfv_pkg::PH_CMD;
      cmd_cand  <= '1;
      pos       <= '0;
      key_cand  <= '1;
      lf_colon  <= 1'b0;
      lf_value  <= 1'b0;
      lf_keyok  <= 1'b0;
      cur_key   <= '0;
      seen      <= '0;
      len_val   <= '0;
      len_digit <= 1'b0;
      len_stop  <= 1'b0;
      body_cnt  <= '0;
      err       <= sfv_pkg::ST_OK;
      cmd_found <= '0;
    end else if (push) begin
      phase     <= phase_next;
      cmd_cand  <= cmd_cand_next;
      pos       <= pos_next;
      key_cand  <= key_cand_next;
      lf_colon  <= lf_colon_next;
      lf_value  <= lf_value_next;
      lf_keyok  <= lf_keyok_next;
      cur_key   <= cur_key_next;
      seen      <= seen_next;
      len_val   <= len_val_next;
      len_digit <= len_digit_next;
      len_stop  <= len_stop_next;
      body_cnt  <= body_cnt_next;
      err       <= err_next;
      cmd_found <= cmd_found_next;
    end
  end

  // a set error means the phase walk has stopped
  a_err_freezes_phase: assert property (@(posedge clk) disable iff (rst)
    (push && !frame_last && err != sfv_pkg::ST_OK) |=> $stable(phase))
    else $error("phase moved after an error");

  a_body_in_range: assert property (@(posedge clk) disable iff (rst)
    (phase == sfv_pkg::PH_BLEN) |-> (body_cnt <= len_val))
    else $error("body count beyond content length");

  a_colon_in_value: assert property (@(posedge clk) disable iff (rst)
    (phase == sfv_pkg::PH_VAL) |-> lf_colon)
    else $error("value phase without a colon");

endmodule

/* rtl/sfv_out_buf.sv */
module sfv_out_buf (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  sfv_pkg::result_t push_data,
  output logic             ready,
  output logic             out_valid,
  input  logic             out_ready,
  output sfv_pkg::result_t out_data
);

  logic             skid_valid;
  sfv_pkg::result_t skid_data;

  assign ready = !skid_valid;

  // output register with one skid entry behind it
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (push) begin
      if (!out_valid || out_ready) begin
        out_valid <= 1'b1;
      end else begin
        skid_valid <= 1'b1;
      end
    end else if (out_ready) begin
      if (skid_valid) begin
        skid_valid <= 1'b0;
      end else begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      if (!out_valid || out_ready) out_data <= push_data;
      else skid_data <= push_data;
    end else if (out_ready && skid_valid) begin
      out_data <= skid_data;
    end
  end

  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid entry held with empty output register");

  a_push_lands: assert property (@(posedge clk) disable iff (rst)
    push |=> out_valid)
    else $error("accepted request not shown");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_data)))
    else $error("stalled result changed");

endmodule
